// ----- rtl/core/rcpg_pkg.sv -----
package rcpg_pkg;

  localparam int unsigned HUE_FULL   = 360;
  localparam int unsigned REGION_DEG = 60;
  localparam int unsigned CH_MAX     = 255;
  localparam int unsigned QDEPTH     = 4;
  localparam int unsigned QPTR_W     = 2;

  // configuration register indexes
  localparam logic [1:0] CFG_BRIGHTNESS = 2'd0;
  localparam logic [1:0] CFG_SATURATION = 2'd1;
  localparam logic [1:0] CFG_HUE_STEP   = 2'd2;

  typedef struct packed {
    logic [7:0] brightness;
    logic [7:0] saturation;
    logic [8:0] hue_step;
  } cfg_t;

  // one pixel request between front and back
  typedef struct packed {
    logic [3:0] led_index;
    logic [8:0] hue;
    logic       last;
  } pix_req_t;

endpackage

// ----- rtl/core/rcpg_front.sv -----
module rcpg_front #(
  parameter int unsigned NUM_LEDS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  rcpg_pkg::cfg_t    cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_restart,
  input  logic              q_full,
  output logic              q_push,
  output rcpg_pkg::pix_req_t q_data
);
  import rcpg_pkg::*;

  localparam int unsigned IW   = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
  localparam int unsigned HQ   = HUE_FULL / NUM_LEDS;
  localparam int unsigned HR   = HUE_FULL % NUM_LEDS;
  localparam logic [IW-1:0] LAST_IDX = IW'(NUM_LEDS - 1);

  logic          busy_r, busy_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [8:0]    base_r, base_nxt;
  logic [6:0]    frac_r, frac_nxt;
  logic [8:0]    offset_r, offset_nxt;

  logic          is_last;
  logic          accept;
  logic [9:0]    hue_sum;
  logic [8:0]    hue;
  logic [9:0]    adv;
  logic [8:0]    adv_mod;
  logic [7:0]    frac_sum;
  logic [9:0]    base_sum;
  logic [IW+3:0] idx_ext;

  always_comb begin
    is_last  = (idx_r == LAST_IDX);
    q_push   = busy_r && !q_full;
    in_ready = !busy_r || (q_push && is_last);
    accept   = in_valid && in_ready;

    hue_sum = {1'b0, base_r} + {1'b0, offset_r};
    hue     = (hue_sum >= 10'(HUE_FULL)) ? 9'(hue_sum - 10'(HUE_FULL)) : hue_sum[8:0];

    adv = {1'b0, offset_r} + {1'b0, cfg.hue_step};
    if (adv >= 10'(2 * HUE_FULL)) begin
      adv_mod = 9'(adv - 10'(2 * HUE_FULL));
    end else if (adv >= 10'(HUE_FULL)) begin
      adv_mod = 9'(adv - 10'(HUE_FULL));
    end else begin
      adv_mod = adv[8:0];
    end

    // base hue steps by 360/N with the remainder carried exactly
    frac_sum = {1'b0, frac_r} + 8'(HR);
    base_sum = {1'b0, base_r} + 10'(HQ);
    idx_ext  = {4'b0, idx_r};

    q_data.led_index = idx_ext[3:0];
    q_data.hue       = hue;
    q_data.last      = is_last;

    busy_nxt   = busy_r;
    idx_nxt    = idx_r;
    base_nxt   = base_r;
    frac_nxt   = frac_r;
    offset_nxt = offset_r;

    if (q_push) begin
      idx_nxt = idx_r + IW'(1);
      if (frac_sum >= 8'(NUM_LEDS)) begin
        frac_nxt = 7'(frac_sum - 8'(NUM_LEDS));
        base_nxt = 9'(base_sum + 10'd1);
      end else begin
        frac_nxt = frac_sum[6:0];
        base_nxt = base_sum[8:0];
      end
      if (is_last) begin
        busy_nxt   = 1'b0;
        offset_nxt = adv_mod;
      end
    end

    if (accept) begin
      busy_nxt = 1'b1;
      idx_nxt  = '0;
      base_nxt = '0;
      frac_nxt = '0;
      if (in_restart) begin
        offset_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      idx_r    <= '0;
      base_r   <= '0;
      frac_r   <= '0;
      offset_r <= '0;
    end else begin
      busy_r   <= busy_nxt;
      idx_r    <= idx_nxt;
      base_r   <= base_nxt;
      frac_r   <= frac_nxt;
      offset_r <= offset_nxt;
    end
  end

endmodule

// ----- rtl/core/rcpg_fifo.sv -----
module rcpg_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  rcpg_pkg::pix_req_t wdata,
  output logic               full,
  input  logic               pop,
  output logic               empty,
  output rcpg_pkg::pix_req_t rdata
);
  import rcpg_pkg::*;

  pix_req_t            mem_r [QDEPTH];
  logic [QPTR_W-1:0]   wptr_r, wptr_nxt;
  logic [QPTR_W-1:0]   rptr_r, rptr_nxt;
  logic [QPTR_W:0]     cnt_r, cnt_nxt;
  logic                do_push, do_pop;

  always_comb begin
    full     = (cnt_r == (QPTR_W+1)'(QDEPTH));
    empty    = (cnt_r == '0);
    do_push  = push && !full;
    do_pop   = pop && !empty;
    rdata    = mem_r[rptr_r];
    wptr_nxt = do_push ? wptr_r + QPTR_W'(1) : wptr_r;
    rptr_nxt = do_pop ? rptr_r + QPTR_W'(1) : rptr_r;
    cnt_nxt  = cnt_r + (QPTR_W+1)'(do_push) - (QPTR_W+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

// ----- rtl/core/rcpg_back.sv -----
module rcpg_back (
  input  logic               clk,
  input  logic               rst_n,
  input  rcpg_pkg::cfg_t     cfg,
  input  logic               q_empty,
  output logic               q_pop,
  input  rcpg_pkg::pix_req_t q_data,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [3:0]         out_led_index,
  output logic [7:0]         out_red,
  output logic [7:0]         out_green,
  output logic [7:0]         out_blue,
  output logic               out_last_of_frame
);
  import rcpg_pkg::*;

  // hue regions, 60 degrees each
  localparam logic [2:0] RGN_RED     = 3'd0;
  localparam logic [2:0] RGN_YELLOW  = 3'd1;
  localparam logic [2:0] RGN_GREEN   = 3'd2;
  localparam logic [2:0] RGN_CYAN    = 3'd3;
  localparam logic [2:0] RGN_BLUE    = 3'd4;
  localparam logic [2:0] RGN_MAGENTA = 3'd5;

  logic       en;
  logic       v1_r, v2_r, v3_r, ov_r;

  // stage 1: region and scaled remainder
  logic [2:0] rg1_r;
  logic [7:0] rem1_r;
  logic [3:0] idx1_r;
  logic       last1_r;
  // stage 2: saturation products and p
  logic [2:0] rg2_r;
  logic [7:0] sr2_r, sn2_r, p2_r;
  logic [3:0] idx2_r;
  logic       last2_r;
  // stage 3: q and t
  logic [2:0] rg3_r;
  logic [7:0] p3_r, q3_r, t3_r;
  logic [3:0] idx3_r;
  logic       last3_r;
  // output register
  logic [3:0] oidx_r;
  logic [7:0] ored_r, ogrn_r, oblu_r;
  logic       olast_r;

  logic [2:0]  rg;
  logic [8:0]  hsub;
  logic [9:0]  rem_x17;
  logic [15:0] sr_prod, sn_prod, p_prod, q_prod, t_prod;
  logic [7:0]  r_sel, g_sel, b_sel;

  always_comb begin
    en    = !ov_r || out_ready;
    q_pop = en && !q_empty;

    if (q_data.hue >= 9'(5 * REGION_DEG)) begin
      rg = RGN_MAGENTA; hsub = q_data.hue - 9'(5 * REGION_DEG);
    end else if (q_data.hue >= 9'(4 * REGION_DEG)) begin
      rg = RGN_BLUE;    hsub = q_data.hue - 9'(4 * REGION_DEG);
    end else if (q_data.hue >= 9'(3 * REGION_DEG)) begin
      rg = RGN_CYAN;    hsub = q_data.hue - 9'(3 * REGION_DEG);
    end else if (q_data.hue >= 9'(2 * REGION_DEG)) begin
      rg = RGN_GREEN;   hsub = q_data.hue - 9'(2 * REGION_DEG);
    end else if (q_data.hue >= 9'(REGION_DEG)) begin
      rg = RGN_YELLOW;  hsub = q_data.hue - 9'(REGION_DEG);
    end else begin
      rg = RGN_RED;     hsub = q_data.hue;
    end
    // 255/60 is exactly 17/4
    rem_x17 = {4'b0, hsub[5:0]} * 10'd17;

    sr_prod = cfg.saturation * rem1_r;
    sn_prod = cfg.saturation * (8'(CH_MAX) - rem1_r);
    p_prod  = cfg.brightness * (8'(CH_MAX) - cfg.saturation);

    q_prod = cfg.brightness * (8'(CH_MAX) - sr2_r);
    t_prod = cfg.brightness * (8'(CH_MAX) - sn2_r);

    case (rg3_r)
      RGN_RED:    begin r_sel = cfg.brightness; g_sel = t3_r; b_sel = p3_r; end
      RGN_YELLOW: begin r_sel = q3_r; g_sel = cfg.brightness; b_sel = p3_r; end
      RGN_GREEN:  begin r_sel = p3_r; g_sel = cfg.brightness; b_sel = t3_r; end
      RGN_CYAN:   begin r_sel = p3_r; g_sel = q3_r; b_sel = cfg.brightness; end
      RGN_BLUE:   begin r_sel = t3_r; g_sel = p3_r; b_sel = cfg.brightness; end
      default:    begin r_sel = cfg.brightness; g_sel = p3_r; b_sel = q3_r; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rg1_r   <= rg;
      rem1_r  <= rem_x17[9:2];
      idx1_r  <= q_data.led_index;
      last1_r <= q_data.last;

      rg2_r   <= rg1_r;
      sr2_r   <= sr_prod[15:8];
      sn2_r   <= sn_prod[15:8];
      p2_r    <= p_prod[15:8];
      idx2_r  <= idx1_r;
      last2_r <= last1_r;

      rg3_r   <= rg2_r;
      p3_r    <= p2_r;
      q3_r    <= q_prod[15:8];
      t3_r    <= t_prod[15:8];
      idx3_r  <= idx2_r;
      last3_r <= last2_r;

      oidx_r  <= idx3_r;
      ored_r  <= r_sel;
      ogrn_r  <= g_sel;
      oblu_r  <= b_sel;
      olast_r <= last3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      ov_r <= 1'b0;
    end else if (en) begin
      v1_r <= q_pop;
      v2_r <= v1_r;
      v3_r <= v2_r;
      ov_r <= v3_r;
    end
  end

  assign out_valid         = ov_r;
  assign out_led_index     = oidx_r;
  assign out_red           = ored_r;
  assign out_green         = ogrn_r;
  assign out_blue          = oblu_r;
  assign out_last_of_frame = olast_r;

endmodule

// ----- rtl/core/rainbow_chase_pixel_generator.sv -----
// rainbow chase pixel generator: each accepted request is one frame tick and
// yields NUM_LEDS pixel results in LED order, the final one flagged with
// out_last_of_frame. pixel i gets hue i*360/NUM_LEDS plus a running offset
// (mod 360), converted to rgb with six 60-degree regions and p/q/t terms
// scaled by >>8 using the configured saturation and brightness. in_restart
// zeroes the offset before the frame; after the frame the offset advances
// by hue_step mod 360. the front sequencer issues one pixel per cycle
// while the queue is not full; the next tick is taken on the cycle the
// last pixel of the current frame is issued. results pass through the
// queue and a four-stage conversion pipeline that stalls as a whole on
// out_ready. configuration is written through cfg_we / cfg_index /
// cfg_wdata while the block is idle.
module rainbow_chase_pixel_generator #(
  parameter int unsigned NUM_LEDS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [8:0] cfg_wdata,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_restart,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [3:0] out_led_index,
  output logic [7:0] out_red,
  output logic [7:0] out_green,
  output logic [7:0] out_blue,
  output logic       out_last_of_frame
);
  import rcpg_pkg::*;

  cfg_t     cfg_r, cfg_nxt;
  logic     q_push, q_full, q_pop, q_empty;
  pix_req_t q_wdata, q_rdata;

  // config registers, index beyond the list is ignored
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_BRIGHTNESS: cfg_nxt.brightness = cfg_wdata[7:0];
        CFG_SATURATION: cfg_nxt.saturation = cfg_wdata[7:0];
        CFG_HUE_STEP:   cfg_nxt.hue_step   = cfg_wdata;
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.brightness <= 8'd5;
      cfg_r.saturation <= 8'd255;
      cfg_r.hue_step   <= 9'd5;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // front: takes frame ticks, walks the leds and issues pixel requests
  rcpg_front #(
    .NUM_LEDS (NUM_LEDS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_restart (in_restart),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_data     (q_wdata)
  );

  // short queue so front and back stall independently
  rcpg_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .empty (q_empty),
    .rdata (q_rdata)
  );

  // back: hue to rgb pipeline with output register
  rcpg_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .q_empty           (q_empty),
    .q_pop             (q_pop),
    .q_data            (q_rdata),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_led_index     (out_led_index),
    .out_red           (out_red),
    .out_green         (out_green),
    .out_blue          (out_blue),
    .out_last_of_frame (out_last_of_frame)
  );

endmodule

// ----- sim/rainbow_chase_pixel_generator_test.sv -----
module rainbow_chase_pixel_generator_test;
  timeunit 1ns;
  timeprecision 1ps;

  import rcpg_pkg::*;

  localparam int unsigned LEDS          = 16;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned SETTLE_CYCLES = 10;   // pipeline is four deep
  localparam int unsigned HOLD_CYCLES   = 300;  // long receiver hold-off
  localparam int unsigned RANDOM_PHASES = 8;
  localparam int unsigned PHASE_TICKS   = 25;

  // index past the register list, writes to it must be ignored
  localparam logic [1:0] CFG_UNUSED = 2'd3;

  // one frame tick request waiting to be driven
  typedef struct {
    logic        restart;
    int unsigned gap;
    bit          drain;   // hold the request until every pixel has come back
  } tick_t;

  typedef struct packed {
    logic [3:0] led_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } pixel_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_we = 1'b0;
  logic [1:0] cfg_index = CFG_BRIGHTNESS;
  logic [8:0] cfg_wdata = '0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic       in_restart = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [3:0] out_led_index;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic       out_last_of_frame;

  rainbow_chase_pixel_generator #(
    .NUM_LEDS(LEDS)
  ) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_restart       (in_restart),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_led_index    (out_led_index),
    .out_red          (out_red),
    .out_green        (out_green),
    .out_blue         (out_blue),
    .out_last_of_frame(out_last_of_frame)
  );

  // model state: register copy and running hue offset
  cfg_t        cfg_model;
  int unsigned hue_offset;

  tick_t       tick_queue[$];   // requests not yet driven
  pixel_t      pixel_queue[$];  // pixels predicted but not yet received
  tick_t       cur_tick;
  bit          tick_open;       // a request is staged or offered and not yet taken
  int unsigned gap_left;
  bit          in_taken;
  bit          out_taken;
  pixel_t      want;

  // receiver shaping
  int unsigned rx_max;
  int unsigned rx_wait;
  int unsigned hold_left;
  int unsigned stall_asks;
  int unsigned stall_seen;

  int unsigned cycle_count;
  int unsigned error_count;
  int unsigned ticks_taken;
  int unsigned restarts_taken;
  int unsigned pixels_checked;
  int unsigned reg_writes;

  // clock, 20 ns period
  initial begin
    forever #10 clk = ~clk;
  end

  // hsv to rgb with six 60-degree regions and p/q/t scaled by >>8
  function automatic pixel_t hsv_pixel(input int unsigned hue, input int unsigned sat,
                                       input int unsigned val);
    int unsigned region;
    int unsigned frac;
    int unsigned p;
    int unsigned q;
    int unsigned t;
    pixel_t      px;
    region = hue / REGION_DEG;
    frac   = (hue - region * REGION_DEG) * CH_MAX / REGION_DEG;
    p = ((val * (CH_MAX - sat)) >> 8) & 32'hFF;
    q = ((val * (CH_MAX - ((sat * frac) >> 8))) >> 8) & 32'hFF;
    t = ((val * (CH_MAX - ((sat * (CH_MAX - frac)) >> 8))) >> 8) & 32'hFF;
    px = '0;
    case (region)
      0: begin
        px.red = 8'(val); px.green = 8'(t); px.blue = 8'(p);
      end
      1: begin
        px.red = 8'(q); px.green = 8'(val); px.blue = 8'(p);
      end
      2: begin
        px.red = 8'(p); px.green = 8'(val); px.blue = 8'(t);
      end
      3: begin
        px.red = 8'(p); px.green = 8'(q); px.blue = 8'(val);
      end
      4: begin
        px.red = 8'(t); px.green = 8'(p); px.blue = 8'(val);
      end
      default: begin
        px.red = 8'(val); px.green = 8'(p); px.blue = 8'(q);
      end
    endcase
    return px;
  endfunction

  // predict the whole strip for one accepted tick, then advance the offset
  task automatic render_frame(input logic restart);
    int unsigned led;
    int unsigned hue;
    pixel_t      px;
    if (restart) begin
      hue_offset = 0;
    end
    for (led = 0; led < LEDS; led++) begin
      hue = (led * HUE_FULL / LEDS + hue_offset) % HUE_FULL;
      px = hsv_pixel(hue, cfg_model.saturation, cfg_model.brightness);
      px.led_index = 4'(led);
      px.last = (led == LEDS - 1);
      pixel_queue.push_back(px);
    end
    hue_offset = (hue_offset + cfg_model.hue_step) % HUE_FULL;
  endtask

  // register write, only called while the block is idle
  task automatic write_reg(input logic [1:0] idx, input logic [8:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      CFG_BRIGHTNESS: cfg_model.brightness = data[7:0];
      CFG_SATURATION: cfg_model.saturation = data[7:0];
      CFG_HUE_STEP:   cfg_model.hue_step   = data;
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic queue_tick(input logic restart, input int unsigned gap_max, input bit drain);
    tick_t tk;
    tk.restart = restart;
    tk.gap     = $urandom_range(0, gap_max);
    tk.drain   = drain;
    tick_queue.push_back(tk);
  endtask

  // everything driven, taken and received, then let the pipeline settle
  task automatic wait_idle();
    while (tick_queue.size() != 0 || tick_open || pixel_queue.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // random 9-bit write data with a chosen low byte, upper bit as noise
  function automatic logic [8:0] byte_wdata(input int unsigned value);
    return {1'($urandom_range(0, 1)), 8'(value)};
  endfunction

  // handshake sampling, output check before new prediction
  always @(posedge clk) begin
    out_taken = rst_n && out_valid && out_ready;
    in_taken  = rst_n && in_valid && in_ready;
    if (out_taken) begin
      if (pixel_queue.size() == 0) begin
        $error("unexpected pixel: led_index %0d rgb %0d/%0d/%0d", out_led_index,
               out_red, out_green, out_blue);
        error_count++;
      end else begin
        want = pixel_queue.pop_front();
        pixels_checked++;
        if (out_led_index !== want.led_index) begin
          $error("led_index mismatch: expected %0d, actual %0d", want.led_index,
                 out_led_index);
          error_count++;
        end
        if (out_red !== want.red) begin
          $error("red mismatch: expected %0d, actual %0d", want.red, out_red);
          error_count++;
        end
        if (out_green !== want.green) begin
          $error("green mismatch: expected %0d, actual %0d", want.green, out_green);
          error_count++;
        end
        if (out_blue !== want.blue) begin
          $error("blue mismatch: expected %0d, actual %0d", want.blue, out_blue);
          error_count++;
        end
        if (out_last_of_frame !== want.last) begin
          $error("last_of_frame mismatch: expected %0d, actual %0d", want.last,
                 out_last_of_frame);
          error_count++;
        end
      end
    end
    if (in_taken) begin
      render_frame(in_restart);
      ticks_taken++;
      if (in_restart) begin
        restarts_taken++;
      end
      tick_open = 1'b0;
    end
  end

  // request driver: gap before each tick, optional drain wait, noise on restart while idle
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (!tick_open && tick_queue.size() != 0) begin
        cur_tick  = tick_queue.pop_front();
        tick_open = 1'b1;
        gap_left  = cur_tick.gap;
      end
      if (tick_open && gap_left == 0 && (!cur_tick.drain || pixel_queue.size() == 0)) begin
        in_valid   <= 1'b1;
        in_restart <= cur_tick.restart;
      end else begin
        in_valid   <= 1'b0;
        in_restart <= 1'($urandom_range(0, 1));
        if (tick_open && gap_left != 0) begin
          gap_left--;
        end
      end
    end
  end

  // receiver: random stall after each pixel, plus a long hold-off on request
  always @(negedge clk) begin
    if (stall_asks != stall_seen) begin
      stall_seen = stall_asks;
      hold_left  = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (rx_wait != 0) begin
      rx_wait--;
      out_ready <= 1'b0;
    end else if (out_taken) begin
      rx_wait = $urandom_range(0, rx_max);
      if (rx_wait == 0) begin
        out_ready <= 1'b1;
      end else begin
        rx_wait--;
        out_ready <= 1'b0;
      end
    end else begin
      out_ready <= 1'b1;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    int unsigned phase;
    int unsigned n;
    int unsigned tx_max;
    int unsigned pick;
    logic [8:0]  step;

    // register reset values
    cfg_model.brightness = 8'd5;
    cfg_model.saturation = 8'd255;
    cfg_model.hue_step   = 9'd5;
    hue_offset = 0;
    rx_max     = 16;

    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: offset starts at zero, restart mid-run
    queue_tick(1'b0, 16, 1'b0);
    queue_tick(1'b0, 16, 1'b0);
    queue_tick(1'b1, 16, 1'b0);
    queue_tick(1'b0, 16, 1'b0);
    wait_idle();

    // full brightness, full saturation
    write_reg(CFG_BRIGHTNESS, 9'h0FF);
    queue_tick(1'b0, 4, 1'b0);
    queue_tick(1'b0, 4, 1'b0);
    wait_idle();

    // dark strip
    write_reg(CFG_BRIGHTNESS, 9'h100);
    queue_tick(1'b0, 4, 1'b0);
    wait_idle();

    // grey: no saturation, upper data bit set on an 8-bit register
    write_reg(CFG_BRIGHTNESS, 9'h1FF);
    write_reg(CFG_SATURATION, 9'h000);
    queue_tick(1'b0, 4, 1'b0);
    queue_tick(1'b1, 4, 1'b0);
    wait_idle();

    // largest legal step, offset wraps past 360
    write_reg(CFG_SATURATION, 9'h1FF);
    write_reg(CFG_HUE_STEP, 9'd359);
    queue_tick(1'b0, 0, 1'b0);
    queue_tick(1'b0, 0, 1'b0);
    queue_tick(1'b0, 0, 1'b0);
    wait_idle();

    // step beyond 359 is still reduced modulo 360
    write_reg(CFG_HUE_STEP, 9'h1FF);
    queue_tick(1'b0, 8, 1'b0);
    queue_tick(1'b0, 8, 1'b0);
    queue_tick(1'b0, 8, 1'b0);
    wait_idle();

    write_reg(CFG_HUE_STEP, 9'd0);
    queue_tick(1'b0, 8, 1'b0);
    queue_tick(1'b0, 8, 1'b0);
    wait_idle();
    write_reg(CFG_HUE_STEP, 9'd360);
    queue_tick(1'b0, 8, 1'b0);
    queue_tick(1'b0, 8, 1'b0);
    wait_idle();

    // write past the register list is dropped
    write_reg(CFG_UNUSED, 9'h0AA);
    queue_tick(1'b0, 8, 1'b0);
    wait_idle();

    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      // fresh register settings, extremes weighted in
      pick = $urandom_range(0, 3);
      write_reg(CFG_BRIGHTNESS, byte_wdata(pick == 0 ? 0 : pick == 1 ? 255 :
                                           $urandom_range(0, 255)));
      pick = $urandom_range(0, 3);
      write_reg(CFG_SATURATION, byte_wdata(pick == 0 ? 0 : pick == 1 ? 255 :
                                           $urandom_range(0, 255)));
      case ($urandom_range(0, 4))
        0:       step = 9'd0;
        1:       step = 9'd359;
        2:       step = 9'($urandom_range(360, 511));
        default: step = 9'($urandom_range(0, 359));
      endcase
      write_reg(CFG_HUE_STEP, step);
      if ($urandom_range(0, 2) == 0) begin
        write_reg(CFG_UNUSED, 9'($urandom_range(0, 511)));
      end

      // first phase runs flat out, pressure phase streams with no sender gaps
      case (phase)
        0: begin
          tx_max = 0;
          rx_max = 0;
        end
        2: begin
          tx_max = 0;
          rx_max = 4;
        end
        default: begin
          tx_max = ($urandom_range(0, 1) == 0) ? 16 : $urandom_range(0, 16);
          rx_max = ($urandom_range(0, 1) == 0) ? 16 : $urandom_range(0, 16);
        end
      endcase

      for (n = 0; n < PHASE_TICKS; n++) begin
        queue_tick($urandom_range(0, 7) == 0, tx_max,
                   (phase == 4 && n == 12) || $urandom_range(0, 19) == 0);
      end
      if (phase == 2) begin
        // receiver holds off while the sender keeps offering, block fills and stalls
        stall_asks++;
      end
      wait_idle();
    end

    $display("covered %0d frame ticks (%0d with restart), %0d pixels checked, %0d reg writes",
             ticks_taken, restarts_taken, pixels_checked, reg_writes);
    $display("brightness/saturation extremes, hue steps 0..511, back-pressure hold and drain");
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
